### sv/lpi_pkg.sv
package lpi_pkg;

  // Result coordinate width and quotient width (one guard bit for saturation)
  localparam int OUT_W   = 48;
  localparam int QUOT_W  = OUT_W + 1;
  // Divider depth: one setup stage plus one stage per quotient bit
  localparam int DIV_LAT = QUOT_W + 1;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Relation codes
  localparam logic [1:0] REL_PARALLEL   = 2'd0;
  localparam logic [1:0] REL_INTERSECT  = 2'd1;
  localparam logic [1:0] REL_COINCIDENT = 2'd2;

  // Control that travels beside the divider stages
  typedef struct packed {
    logic       valid;
    logic [1:0] relation;
  } lpi_ctl_t;

endpackage

### sv/line_pair_intersection.sv
// Line pair intersection by Cramer's rule. Each request carries two lines, each
// given by two signed points; the result gives the relation (parallel, single
// intersection, coincident), the crossing point in signed fixed point with
// FRAC_BITS fraction bits (truncated toward zero, saturated to 48 bits with an
// overflow flag) and zeros when the lines do not cross at one point. The block
// is fully pipelined: one request is taken every cycle while the output is not
// stalled, and its result passes through the input register, four arithmetic
// stages, the 50-stage quotient pipeline (one bit per stage) and the output
// register. A stalled output freezes the whole pipeline; nothing is lost or
// repeated.
module line_pair_intersection #(
  parameter int COORD_WIDTH = lpi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = lpi_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]  line1_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]  line1_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]  line1_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]  line1_end_y_i,
  input  logic signed [COORD_WIDTH-1:0]  line2_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]  line2_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]  line2_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]  line2_end_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     relation_o,
  output logic signed [lpi_pkg::OUT_W-1:0] cross_x_o,
  output logic signed [lpi_pkg::OUT_W-1:0] cross_y_o,
  output logic                           overflow_o
);
  import lpi_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = CW + 1;
  localparam int CWID = 2 * CW + 1;
  localparam int KL   = CW + 1;
  localparam int PW   = 2 * CW + 3;
  localparam int NUMW = 3 * CW + 3;
  localparam int NMW  = NUMW + FRAC_BITS;
  localparam int DMW  = PW;

  logic en;

  // Stage 0: input registers
  logic                 v0_q;
  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;

  // Stage 1: line coefficients
  logic                   v1_q;
  logic signed [AW-1:0]   a1_q, b1_q, a2_q, b2_q;
  logic signed [CWID-1:0] c1_q, c2_q;

  // Stage 2: partial products
  logic                 v2_q;
  logic signed [PW-1:0] det2_q, hx_q, lx_q, hy_q, ly_q;

  // Stage 3: numerators
  logic                   v3_q;
  logic signed [PW-1:0]   det3_q;
  logic signed [NUMW-1:0] nx_q, ny_q;

  // Stage 4: magnitudes and relation
  lpi_ctl_t          ctl4_q;
  logic [NMW-1:0]    mx_q, my_q;
  logic [DMW-1:0]    dm_q;
  logic              sx_q, sy_q;

  lpi_ctl_t          ctl_q [DIV_LAT];

  logic [OUT_W-1:0]  qx, qy;
  logic              satx, saty;

  logic              out_valid_q;
  logic [1:0]        relation_q;
  logic [OUT_W-1:0]  cross_x_q, cross_y_q;
  logic              overflow_q;

  // Freeze everything while a result waits on a stalled output
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      ctl4_q      <= '0;
      for (int i = 0; i < DIV_LAT; i++) ctl_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q         <= in_valid_i;
      v1_q         <= v0_q;
      v2_q         <= v1_q;
      v3_q         <= v2_q;
      ctl4_q.valid <= v3_q;
      if (det3_q == '0) begin
        ctl4_q.relation <= (nx_q == '0 && ny_q == '0) ? REL_COINCIDENT : REL_PARALLEL;
      end else begin
        ctl4_q.relation <= REL_INTERSECT;
      end
      ctl_q[0] <= ctl4_q;
      for (int i = 1; i < DIV_LAT; i++) ctl_q[i] <= ctl_q[i-1];
      out_valid_q <= ctl_q[DIV_LAT-1].valid;
    end
  end

  // Arithmetic stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      // capture request
      x1_q <= line1_start_x_i;
      y1_q <= line1_start_y_i;
      x2_q <= line1_end_x_i;
      y2_q <= line1_end_y_i;
      x3_q <= line2_start_x_i;
      y3_q <= line2_start_y_i;
      x4_q <= line2_end_x_i;
      y4_q <= line2_end_y_i;

      // coefficients a, b, c
      a1_q <= AW'(y2_q) - AW'(y1_q);
      b1_q <= AW'(x1_q) - AW'(x2_q);
      a2_q <= AW'(y4_q) - AW'(y3_q);
      b2_q <= AW'(x3_q) - AW'(x4_q);
      c1_q <= CWID'(x1_q) * CWID'(y2_q) - CWID'(x2_q) * CWID'(y1_q);
      c2_q <= CWID'(x3_q) * CWID'(y4_q) - CWID'(x4_q) * CWID'(y3_q);

      // determinant and split cross products (upper halves are signed)
      det2_q <= PW'(a1_q) * PW'(b2_q) - PW'(b1_q) * PW'(a2_q);
      hx_q   <= PW'(signed'(c1_q[CWID-1:KL])) * PW'(b2_q)
              - PW'(b1_q) * PW'(signed'(c2_q[CWID-1:KL]));
      lx_q   <= PW'(signed'({1'b0, c1_q[KL-1:0]})) * PW'(b2_q)
              - PW'(b1_q) * PW'(signed'({1'b0, c2_q[KL-1:0]}));
      hy_q   <= PW'(a1_q) * PW'(signed'(c2_q[CWID-1:KL]))
              - PW'(signed'(c1_q[CWID-1:KL])) * PW'(a2_q);
      ly_q   <= PW'(a1_q) * PW'(signed'({1'b0, c2_q[KL-1:0]}))
              - PW'(signed'({1'b0, c1_q[KL-1:0]})) * PW'(a2_q);

      // join halves into full numerators
      det3_q <= det2_q;
      nx_q   <= (NUMW'(hx_q) <<< KL) + NUMW'(lx_q);
      ny_q   <= (NUMW'(hy_q) <<< KL) + NUMW'(ly_q);

      // magnitudes, scaled numerators and quotient signs
      mx_q <= NMW'(nx_q[NUMW-1] ? NUMW'(0 - nx_q) : NUMW'(nx_q)) << FRAC_BITS;
      my_q <= NMW'(ny_q[NUMW-1] ? NUMW'(0 - ny_q) : NUMW'(ny_q)) << FRAC_BITS;
      dm_q <= det3_q[PW-1] ? DMW'(0 - det3_q) : DMW'(det3_q);
      sx_q <= nx_q[NUMW-1] ^ det3_q[PW-1];
      sy_q <= ny_q[NUMW-1] ^ det3_q[PW-1];
    end
  end

  lpi_div #(.NMW(NMW), .DMW(DMW)) u_div_x (
    .clk_i     (clk_i),
    .en_i      (en),
    .num_mag_i (mx_q),
    .neg_i     (sx_q),
    .den_i     (dm_q),
    .res_o     (qx),
    .sat_o     (satx)
  );

  lpi_div #(.NMW(NMW), .DMW(DMW)) u_div_y (
    .clk_i     (clk_i),
    .en_i      (en),
    .num_mag_i (my_q),
    .neg_i     (sy_q),
    .den_i     (dm_q),
    .res_o     (qy),
    .sat_o     (saty)
  );

  // Output register; zero the point unless there is one intersection
  always_ff @(posedge clk_i) begin
    if (en) begin
      relation_q <= ctl_q[DIV_LAT-1].relation;
      if (ctl_q[DIV_LAT-1].relation == REL_INTERSECT) begin
        cross_x_q  <= qx;
        cross_y_q  <= qy;
        overflow_q <= satx || saty;
      end else begin
        cross_x_q  <= '0;
        cross_y_q  <= '0;
        overflow_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign relation_o  = relation_q;
  assign cross_x_o   = cross_x_q;
  assign cross_y_o   = cross_y_q;
  assign overflow_o  = overflow_q;

endmodule

### sv/lpi_div.sv
module lpi_div #(
  parameter int NMW = 67,
  parameter int DMW = 35
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [NMW-1:0]           num_mag_i,
  input  logic                     neg_i,
  input  logic [DMW-1:0]           den_i,
  output logic [lpi_pkg::OUT_W-1:0] res_o,
  output logic                     sat_o
);
  import lpi_pkg::*;

  localparam int NPW = NMW + QUOT_W;

  logic [NPW-1:0]    num_pad;
  logic [NPW-1:0]    num_top;
  logic              ovf_0;
  logic [DMW-1:0]    rem_0;

  logic [DMW-1:0]    rem_q  [QUOT_W+1];
  logic [QUOT_W-1:0] nlow_q [QUOT_W+1];
  logic [DMW-1:0]    den_q  [QUOT_W+1];
  logic              neg_q  [QUOT_W+1];
  logic              ovf_q  [QUOT_W+1];
  logic [QUOT_W-1:0] quo_q  [QUOT_W+1];

  logic [DMW-1:0]    rem_d  [QUOT_W+1];
  logic [QUOT_W-1:0] quo_d  [QUOT_W+1];

  // Split off the part above the quotient window; it must stay below the divisor
  always_comb begin
    num_pad = NPW'(num_mag_i);
    num_top = num_pad >> QUOT_W;
    ovf_0   = num_top >= NPW'(den_i);
    rem_0   = ovf_0 ? '0 : DMW'(num_top);
  end

  // One restoring step per stage
  always_comb begin
    logic [DMW:0] trial;
    logic         ge;
    rem_d[0] = rem_0;
    quo_d[0] = '0;
    for (int s = 1; s <= QUOT_W; s++) begin
      trial    = {rem_q[s-1], nlow_q[s-1][QUOT_W-s]};
      ge       = trial >= {1'b0, den_q[s-1]};
      rem_d[s] = ge ? DMW'(trial - {1'b0, den_q[s-1]}) : DMW'(trial);
      quo_d[s] = {quo_q[s-1][QUOT_W-2:0], ge};
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_d[0];
      quo_q[0]  <= quo_d[0];
      nlow_q[0] <= num_pad[QUOT_W-1:0];
      den_q[0]  <= den_i;
      neg_q[0]  <= neg_i;
      ovf_q[0]  <= ovf_0;
      for (int s = 1; s <= QUOT_W; s++) begin
        rem_q[s]  <= rem_d[s];
        quo_q[s]  <= quo_d[s];
        nlow_q[s] <= nlow_q[s-1];
        den_q[s]  <= den_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
      end
    end
  end

  // Apply sign and saturate to the output range
  always_comb begin
    logic [QUOT_W-1:0] q;
    q = quo_q[QUOT_W];
    if (neg_q[QUOT_W]) begin
      sat_o = ovf_q[QUOT_W] || (q > (QUOT_W'(1) << (OUT_W - 1)));
      res_o = sat_o ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(0 - q[OUT_W-1:0]);
    end else begin
      sat_o = ovf_q[QUOT_W] || (q[QUOT_W-1:QUOT_W-2] != 2'b00);
      res_o = sat_o ? {1'b0, {(OUT_W-1){1'b1}}} : q[OUT_W-1:0];
    end
  end

endmodule
